FILE: rtl/log_record_deframer_crc32_top_assert.svh
// Assertion macros for the log record deframer.
// Included inside the modules that carry concurrent checks; needs a clock and reset in scope.
`ifndef LOG_RECORD_DEFRAMER_CRC32_TOP_ASSERT_SVH
`define LOG_RECORD_DEFRAMER_CRC32_TOP_ASSERT_SVH

// check gated off during reset
`define LRD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds through reset
`define LRD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/lrd_pkg.sv
// Shared types, codes and the CRC-32 byte update for the log record deframer.
// No dependencies.
`timescale 1ns / 1ps

package lrd_pkg;

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   localparam logic [2:0] KIND_KEY       = 3'd0;
   localparam logic [2:0] KIND_VALUE     = 3'd1;
   localparam logic [2:0] KIND_GOOD      = 3'd2;
   localparam logic [2:0] KIND_CRC_BAD   = 3'd3;
   localparam logic [2:0] KIND_TRUNCATED = 3'd4;

   localparam logic [1:0] CSR_CHECKPOINT = 2'd0;
   localparam logic [1:0] CSR_PUT_CODE   = 2'd1;
   localparam logic [1:0] CSR_DEL_CODE   = 2'd2;

   localparam int RSP_DATA_W = 152;
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [63:0] sequence_number;
      logic [31:0] transaction_id;
      logic [7:0]  record_type;
      logic        after_checkpoint;
      logic [15:0] key_length;
      logic [15:0] value_length;
      logic        last_of_item;
   } rsp_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/log_record_deframer_crc32_top.sv
// Log record deframer top: byte-serial parse, CRC-32 check and result queue.
// Depends on lrd_pkg and log_record_deframer_crc32_top_assert.svh.
// A result word is written into the result queue at the edge that accepts its byte.
// Input: one byte per cycle while the result queue holds two words or fewer; a byte
// giving two results drains as two words from the four-entry result queue, one per pop.
// Reset: synchronous, active high; clears parser state, registers and the queue.
`timescale 1ns / 1ps

module log_record_deframer_crc32_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] stream_byte
   input  logic         req_tlast,   // end_of_stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // data_byte, sequence_number, transaction_id,
                                     // record_type, after_checkpoint, key_length,
                                     // value_length, zero pad
   output logic [2:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,   // last_of_item
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);

   typedef enum logic [3:0] {
      PH_CRC, PH_SEQ, PH_TXN, PH_TYPE, PH_PKLEN, PH_PKEY, PH_DKLEN, PH_DKEY, PH_VLEN, PH_VAL
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [31:0] stored_crc_ff, stored_crc_in;
   logic [31:0] running_crc_ff, running_crc_in;
   logic [63:0] seq_ff, seq_in;
   logic [31:0] txn_ff, txn_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] key_len_ff, key_len_in;
   logic [15:0] value_len_ff, value_len_in;
   logic        halted_ff, halted_in;

   logic [63:0] checkpoint_ff;
   logic [7:0]  put_code_ff;
   logic [7:0]  del_code_ff;

   lrd_pkg::rsp_type fifo_ff [lrd_pkg::FIFO_DEPTH];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;

   logic        accept, pop, done, good, has_data;
   logic [7:0]  b;
   logic [15:0] cnt_inc;
   logic [2:0]  data_kind;
   logic [1:0]  push_n;
   lrd_pkg::rsp_type data_res, end_res, first_res;

   assign b          = req_tdata;
   assign req_tready = (count_ff <= 3'd2);
   assign accept     = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;
   assign csr_ready  = 1'b1;
   assign cnt_inc    = byte_count_ff + 16'd1;

   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      stored_crc_in  = stored_crc_ff;
      seq_in         = seq_ff;
      txn_in         = txn_ff;
      type_in        = type_ff;
      key_len_in     = key_len_ff;
      value_len_in   = value_len_ff;
      done           = 1'b0;
      has_data       = 1'b0;
      data_kind      = lrd_pkg::KIND_KEY;
      running_crc_in = (phase_ff == PH_CRC) ? running_crc_ff
                                            : lrd_pkg::crc32_byte(running_crc_ff, b);
      case (phase_ff)
         PH_CRC: begin
            stored_crc_in = {b, stored_crc_ff[31:8]};
            byte_count_in = cnt_inc;
            if (cnt_inc == 16'd4) begin
               byte_count_in = '0;
               phase_in      = PH_SEQ;
            end
         end
         PH_SEQ: begin
            seq_in        = {b, seq_ff[63:8]};
            byte_count_in = cnt_inc;
            if (cnt_inc == 16'd8) begin
               byte_count_in = '0;
               phase_in      = PH_TXN;
            end
         end
         PH_TXN: begin
            txn_in        = {b, txn_ff[31:8]};
            byte_count_in = cnt_inc;
            if (cnt_inc == 16'd4) begin
               byte_count_in = '0;
               phase_in      = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_in       = b;
            byte_count_in = '0;
            if (b == put_code_ff) phase_in = PH_PKLEN;
            else if (b == del_code_ff) phase_in = PH_DKLEN;
            else done = 1'b1;
         end
         PH_PKLEN, PH_DKLEN: begin
            key_len_in    = {b, key_len_ff[15:8]};
            byte_count_in = cnt_inc;
            if (cnt_inc == 16'd2) begin
               byte_count_in = '0;
               if (key_len_in != 16'd0) phase_in = (phase_ff == PH_PKLEN) ? PH_PKEY : PH_DKEY;
               else if (phase_ff == PH_PKLEN) phase_in = PH_VLEN;
               else done = 1'b1;
            end
         end
         PH_PKEY, PH_DKEY: begin
            has_data      = 1'b1;
            byte_count_in = cnt_inc;
            if (cnt_inc == key_len_ff) begin
               byte_count_in = '0;
               if (phase_ff == PH_PKEY) phase_in = PH_VLEN;
               else done = 1'b1;
            end
         end
         PH_VLEN: begin
            value_len_in  = {b, value_len_ff[15:8]};
            byte_count_in = cnt_inc;
            if (cnt_inc == 16'd2) begin
               byte_count_in = '0;
               if (value_len_in != 16'd0) phase_in = PH_VAL;
               else done = 1'b1;
            end
         end
         PH_VAL: begin
            has_data      = 1'b1;
            data_kind     = lrd_pkg::KIND_VALUE;
            byte_count_in = cnt_inc;
            if (cnt_inc == value_len_ff) begin
               byte_count_in = '0;
               done          = 1'b1;
            end
         end
         default: begin
            phase_in = PH_CRC;
         end
      endcase

      good = (~running_crc_in == stored_crc_in);

      data_res              = '0;
      data_res.kind         = data_kind;
      data_res.data_byte    = b;
      data_res.last_of_item = ~(done | req_tlast);

      end_res              = '0;
      end_res.last_of_item = 1'b1;
      if (done) begin
         end_res.kind             = good ? lrd_pkg::KIND_GOOD : lrd_pkg::KIND_CRC_BAD;
         end_res.sequence_number  = seq_in;
         end_res.transaction_id   = txn_in;
         end_res.record_type      = type_in;
         end_res.after_checkpoint = (seq_in > checkpoint_ff);
         end_res.key_length       = key_len_in;
         end_res.value_length     = value_len_in;
      end else begin
         end_res.kind = lrd_pkg::KIND_TRUNCATED;
      end

      first_res = has_data ? data_res : end_res;
      push_n    = (accept && !halted_ff) ? ({1'b0, has_data} + {1'b0, done | req_tlast}) : 2'd0;
      halted_in = halted_ff | (accept & (done ? ~good : req_tlast));

      if (done) begin
         phase_in       = PH_CRC;
         byte_count_in  = '0;
         stored_crc_in  = '0;
         running_crc_in = lrd_pkg::CRC_INIT;
         seq_in         = '0;
         txn_in         = '0;
         type_in        = '0;
         key_len_in     = '0;
         value_len_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_CRC;
         byte_count_ff  <= '0;
         stored_crc_ff  <= '0;
         running_crc_ff <= lrd_pkg::CRC_INIT;
         seq_ff         <= '0;
         txn_ff         <= '0;
         type_ff        <= '0;
         key_len_ff     <= '0;
         value_len_ff   <= '0;
         halted_ff      <= 1'b0;
      end else if (accept && !halted_ff) begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         stored_crc_ff  <= stored_crc_in;
         running_crc_ff <= running_crc_in;
         seq_ff         <= seq_in;
         txn_ff         <= txn_in;
         type_ff        <= type_in;
         key_len_ff     <= key_len_in;
         value_len_ff   <= value_len_in;
         halted_ff      <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         checkpoint_ff <= '0;
         put_code_ff   <= 8'd1;
         del_code_ff   <= 8'd2;
      end else if (csr_valid) begin
         case (csr_index)
            lrd_pkg::CSR_CHECKPOINT: checkpoint_ff <= csr_data;
            lrd_pkg::CSR_PUT_CODE:   put_code_ff   <= csr_data[7:0];
            lrd_pkg::CSR_DEL_CODE:   del_code_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // result queue: up to two words in, one word out per cycle while rsp_tready is high
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) fifo_ff[wr_ptr_ff] <= first_res;
      if (push_n == 2'd2) fifo_ff[wr_ptr_ff + 2'd1] <= end_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push_n;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         count_ff  <= count_ff + {1'b0, push_n} - {2'b0, pop};
      end
   end

   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last_of_item;
   assign rsp_tdata  = {7'd0,
                        fifo_ff[rd_ptr_ff].value_length,
                        fifo_ff[rd_ptr_ff].key_length,
                        fifo_ff[rd_ptr_ff].after_checkpoint,
                        fifo_ff[rd_ptr_ff].record_type,
                        fifo_ff[rd_ptr_ff].transaction_id,
                        fifo_ff[rd_ptr_ff].sequence_number,
                        fifo_ff[rd_ptr_ff].data_byte};

`include "log_record_deframer_crc32_top_assert.svh"

   `LRD_ASSERT(a_count_bound, count_ff <= 3'd4, "result queue overflow")
   `LRD_ASSERT(a_halt_sticky, halted_ff |=> halted_ff, "halt cleared without reset")
   `LRD_ASSERT(a_halt_silent, halted_ff |-> push_n == 2'd0, "result pushed while halted")
   `LRD_ASSERT(a_record_restart, (accept && !halted_ff && done) |=>
      (phase_ff == PH_CRC && byte_count_ff == 16'd0), "record end did not restart parser")
   `LRD_ASSERT(a_push_room, (push_n != 2'd0) |-> count_ff <= 3'd2,
      "push without room for two words")

endmodule

FILE: tb/tb.sv
// Testbench for log_record_deframer_crc32_top: drives framed log records byte by byte
// and checks every result word against an in-bench parser and CRC-32 model.
// Depends on lrd_pkg and the RTL top only.
`timescale 1ns / 1ps

module tb;

   typedef enum logic [3:0] {
      P_CRC, P_SEQ, P_TXN, P_TYPE, P_PKLEN, P_PKEY, P_DKLEN, P_DKEY, P_VLEN, P_VAL
   } parse_phase_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [63:0]  csr_data;

   log_record_deframer_crc32_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // parser model state
   logic [63:0]     cp_lsn;
   logic [7:0]      put_cd;
   logic [7:0]      del_cd;
   parse_phase_type st_phase;
   logic [15:0]     st_cnt;
   logic [31:0]     crc_stored;
   logic [31:0]     crc_acc;
   logic [63:0]     hdr_seq;
   logic [31:0]     hdr_txn;
   logic [7:0]      hdr_type;
   logic [15:0]     hdr_klen;
   logic [15:0]     hdr_vlen;
   logic            is_halted;

   lrd_pkg::rsp_type pending_words[$];
   logic [7:0]       rec_bytes[$];
   int               n_err = 0;
   int               bytes_sent = 0;
   bit               jitter = 0;
   bit               hold_long = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) r = (r >> 1) ^ (lrd_pkg::CRC_POLY & {32{r[0]}});
      return r;
   endfunction

   function automatic lrd_pkg::rsp_type hdr_word(input logic [2:0] k);
      lrd_pkg::rsp_type w;
      w = '0;
      w.kind = k;
      w.sequence_number = hdr_seq;
      w.transaction_id = hdr_txn;
      w.record_type = hdr_type;
      w.after_checkpoint = hdr_seq > cp_lsn;
      w.key_length = hdr_klen;
      w.value_length = hdr_vlen;
      return w;
   endfunction

   function automatic lrd_pkg::rsp_type data_word(input logic [2:0] k, input logic [7:0] b);
      lrd_pkg::rsp_type w;
      w = '0;
      w.kind = k;
      w.data_byte = b;
      return w;
   endfunction

   task automatic clear_record();
      st_phase = P_CRC;
      st_cnt = '0;
      crc_stored = '0;
      crc_acc = lrd_pkg::CRC_INIT;
      hdr_seq = '0;
      hdr_txn = '0;
      hdr_type = '0;
      hdr_klen = '0;
      hdr_vlen = '0;
   endtask

   // advance the parser model by one accepted byte and queue the words it yields
   task automatic parse_byte(input logic [7:0] b, input logic eos);
      lrd_pkg::rsp_type out_words[$];
      logic             done;
      done = 1'b0;
      if (is_halted) return;
      if (st_phase != P_CRC) crc_acc = crc_next(crc_acc, b);
      case (st_phase)
         P_CRC: begin
            crc_stored = {b, crc_stored[31:8]};
            st_cnt++;
            if (st_cnt == 16'd4) begin st_cnt = '0; st_phase = P_SEQ; end
         end
         P_SEQ: begin
            hdr_seq = {b, hdr_seq[63:8]};
            st_cnt++;
            if (st_cnt == 16'd8) begin st_cnt = '0; st_phase = P_TXN; end
         end
         P_TXN: begin
            hdr_txn = {b, hdr_txn[31:8]};
            st_cnt++;
            if (st_cnt == 16'd4) begin st_cnt = '0; st_phase = P_TYPE; end
         end
         P_TYPE: begin
            hdr_type = b;
            st_cnt = '0;
            if (b == put_cd) st_phase = P_PKLEN;
            else if (b == del_cd) st_phase = P_DKLEN;
            else done = 1'b1;
         end
         P_PKLEN, P_DKLEN: begin
            hdr_klen = {b, hdr_klen[15:8]};
            st_cnt++;
            if (st_cnt == 16'd2) begin
               st_cnt = '0;
               if (hdr_klen != 16'd0) st_phase = (st_phase == P_PKLEN) ? P_PKEY : P_DKEY;
               else if (st_phase == P_PKLEN) st_phase = P_VLEN;
               else done = 1'b1;
            end
         end
         P_PKEY, P_DKEY: begin
            out_words = {out_words, data_word(lrd_pkg::KIND_KEY, b)};
            st_cnt++;
            if (st_cnt == hdr_klen) begin
               st_cnt = '0;
               if (st_phase == P_PKEY) st_phase = P_VLEN;
               else done = 1'b1;
            end
         end
         P_VLEN: begin
            hdr_vlen = {b, hdr_vlen[15:8]};
            st_cnt++;
            if (st_cnt == 16'd2) begin
               st_cnt = '0;
               if (hdr_vlen != 16'd0) st_phase = P_VAL;
               else done = 1'b1;
            end
         end
         default: begin
            out_words = {out_words, data_word(lrd_pkg::KIND_VALUE, b)};
            st_cnt++;
            if (st_cnt == hdr_vlen) begin st_cnt = '0; done = 1'b1; end
         end
      endcase
      if (done) begin
         if (~crc_acc == crc_stored) begin
            out_words = {out_words, hdr_word(lrd_pkg::KIND_GOOD)};
         end else begin
            out_words = {out_words, hdr_word(lrd_pkg::KIND_CRC_BAD)};
            is_halted = 1'b1;
         end
         clear_record();
      end else if (eos) begin
         out_words = {out_words, data_word(lrd_pkg::KIND_TRUNCATED, 8'd0)};
         is_halted = 1'b1;
      end
      if (out_words.size() > 0) out_words[out_words.size() - 1].last_of_item = 1'b1;
      foreach (out_words[i]) pending_words = {pending_words, out_words[i]};
   endtask

   // result sink with random stalls and one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_long = 0;
            rsp_tready <= 1'b1;
         end else if (jitter && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
         n_err++;
      end
   endtask

   always @(posedge clock) begin
      lrd_pkg::rsp_type got;
      lrd_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{kind: rsp_tuser, data_byte: rsp_tdata[7:0],
                 sequence_number: rsp_tdata[71:8], transaction_id: rsp_tdata[103:72],
                 record_type: rsp_tdata[111:104], after_checkpoint: rsp_tdata[112],
                 key_length: rsp_tdata[128:113], value_length: rsp_tdata[144:129],
                 last_of_item: rsp_tlast};
         if (pending_words.size() == 0) begin
            $display("%0t unexpected word: expected none actual %h", $time, got);
            n_err++;
         end else begin
            want = pending_words.pop_front();
            check_field("kind", 64'(want.kind), 64'(got.kind));
            check_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
            check_field("sequence_number", want.sequence_number, got.sequence_number);
            check_field("transaction_id", 64'(want.transaction_id),
                        64'(got.transaction_id));
            check_field("record_type", 64'(want.record_type), 64'(got.record_type));
            check_field("after_checkpoint", 64'(want.after_checkpoint),
                        64'(got.after_checkpoint));
            check_field("key_length", 64'(want.key_length), 64'(got.key_length));
            check_field("value_length", 64'(want.value_length), 64'(got.value_length));
            check_field("last_of_item", 64'(want.last_of_item), 64'(got.last_of_item));
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eos);
      if (jitter && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eos;
      do @(posedge clock); while (!req_tready);
      parse_byte(b, eos);
      bytes_sent++;
      @(negedge clock);
   endtask

   // sender stops and waits for every expected word plus the block's latency
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lrd_pkg::CSR_CHECKPOINT: cp_lsn = val;
         lrd_pkg::CSR_PUT_CODE:   put_cd = val[7:0];
         lrd_pkg::CSR_DEL_CODE:   del_cd = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // lays out one record in rec_bytes using the codes as they stand now
   task automatic build_record(input logic [63:0] seq, input logic [31:0] txn,
                               input logic [7:0] rtype, input logic [15:0] klen,
                               input logic [15:0] vlen, input bit corrupt);
      logic [7:0]  body[$];
      logic [31:0] c;
      body = {};
      for (int i = 0; i < 8; i++) body = {body, seq[8*i +: 8]};
      for (int i = 0; i < 4; i++) body = {body, txn[8*i +: 8]};
      body = {body, rtype};
      if (rtype == put_cd || rtype == del_cd) begin
         body = {body, klen[7:0], klen[15:8]};
         for (int i = 0; i < klen; i++) body = {body, 8'($urandom)};
         if (rtype == put_cd) begin
            body = {body, vlen[7:0], vlen[15:8]};
            for (int i = 0; i < vlen; i++) body = {body, 8'($urandom)};
         end
      end
      c = lrd_pkg::CRC_INIT;
      foreach (body[i]) c = crc_next(c, body[i]);
      c = ~c;
      if (corrupt) c = c ^ (32'd1 << $urandom_range(0, 31));
      rec_bytes = {};
      for (int i = 0; i < 4; i++) rec_bytes = {rec_bytes, c[8*i +: 8]};
      foreach (body[i]) rec_bytes = {rec_bytes, body[i]};
   endtask

   task automatic send_span(input int from, input int upto, input logic eos_last);
      for (int i = from; i < upto; i++) send_byte(rec_bytes[i], eos_last && i == upto - 1);
   endtask

   task automatic send_record(input logic [63:0] seq, input logic [31:0] txn,
                              input logic [7:0] rtype, input logic [15:0] klen,
                              input logic [15:0] vlen, input logic eos, input bit corrupt);
      build_record(seq, txn, rtype, klen, vlen, corrupt);
      send_span(0, rec_bytes.size(), eos);
   endtask

   function automatic logic [63:0] pick_seq();
      case ($urandom_range(0, 5))
         0: return cp_lsn;
         1: return cp_lsn + 64'd1;
         2: return cp_lsn - 64'd1;
         3: return 64'd0;
         4: return '1;
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   task automatic test_directed_layouts();
      send_record(64'd0, 32'd0, 8'd1, 16'd1, 16'd1, 1'b0, 1'b0);
      send_record(64'd1, 32'hFFFF_FFFF, 8'd1, 16'd0, 16'd0, 1'b0, 1'b0);
      send_record('1, $urandom, 8'd1, 16'd0, 16'd3, 1'b0, 1'b0);
      send_record(64'h8000_0000_0000_0000, $urandom, 8'd1, 16'd3, 16'd0, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'd2, 16'd2, 16'd0, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'd2, 16'd0, 16'd0, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'hFF, 16'd0, 16'd0, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'd3, 16'd0, 16'd0, 1'b1, 1'b0);
      send_record(pick_seq(), $urandom, 8'd1, 16'd2, 16'd2, 1'b1, 1'b0);
      send_record(pick_seq(), $urandom, 8'd2, 16'd1, 16'd0, 1'b1, 1'b0);
      send_record(pick_seq(), $urandom, 8'd1, 16'd260, 16'd1, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic test_register_settings();
      write_csr(lrd_pkg::CSR_CHECKPOINT, '1);
      send_record('1, $urandom, 8'd1, 16'd1, 16'd1, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'd2, 16'd1, 16'd0, 1'b0, 1'b0);
      write_csr(lrd_pkg::CSR_CHECKPOINT, {32'($urandom), 32'($urandom)});
      send_record(cp_lsn, $urandom, 8'd5, 16'd0, 16'd0, 1'b0, 1'b0);
      send_record(cp_lsn + 64'd1, $urandom, 8'd5, 16'd0, 16'd0, 1'b0, 1'b0);
      send_record(cp_lsn - 64'd1, $urandom, 8'd5, 16'd0, 16'd0, 1'b0, 1'b0);
      write_csr(lrd_pkg::CSR_PUT_CODE, 64'd0);
      write_csr(lrd_pkg::CSR_DEL_CODE, 64'hFF);
      send_record(pick_seq(), $urandom, 8'd0, 16'd1, 16'd2, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'hFF, 16'd2, 16'd0, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'd1, 16'd0, 16'd0, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'd2, 16'd0, 16'd0, 1'b0, 1'b0);
      // equal codes: the type byte counts as a put
      write_csr(lrd_pkg::CSR_PUT_CODE, 64'd7);
      write_csr(lrd_pkg::CSR_DEL_CODE, 64'd7);
      send_record(pick_seq(), $urandom, 8'd7, 16'd1, 16'd1, 1'b0, 1'b0);
      write_csr(lrd_pkg::CSR_PUT_CODE, 64'hFF);
      write_csr(lrd_pkg::CSR_DEL_CODE, 64'd0);
      send_record(pick_seq(), $urandom, 8'hFF, 16'd1, 16'd1, 1'b0, 1'b0);
      send_record(pick_seq(), $urandom, 8'd0, 16'd1, 16'd0, 1'b0, 1'b0);
      write_csr(lrd_pkg::CSR_PUT_CODE, 64'd1);
      write_csr(lrd_pkg::CSR_DEL_CODE, 64'd2);
      write_csr(lrd_pkg::CSR_CHECKPOINT, 64'd0);
   endtask

   // payload class is fixed on the type byte; a later code write must not change it
   task automatic test_code_change_mid_record();
      build_record(pick_seq(), $urandom, 8'd1, 16'd2, 16'd2, 1'b0);
      send_span(0, 18, 1'b0);
      write_csr(lrd_pkg::CSR_PUT_CODE, 64'd9);
      write_csr(lrd_pkg::CSR_DEL_CODE, 64'd1);
      send_span(18, rec_bytes.size(), 1'b0);
      send_record(pick_seq(), $urandom, 8'd1, 16'd2, 16'd0, 1'b0, 1'b0);
      write_csr(lrd_pkg::CSR_PUT_CODE, 64'd1);
      write_csr(lrd_pkg::CSR_DEL_CODE, 64'd2);
   endtask

   task automatic test_output_backpressure();
      jitter = 1;
      hold_long = 1;
      for (int i = 0; i < 4; i++)
         send_record(pick_seq(), $urandom, put_cd, 16'd4, 16'd4, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_stream();
      int          start;
      int          pick;
      logic [7:0]  rtype;
      logic [15:0] klen;
      logic [15:0] vlen;
      logic [63:0] val;
      start = bytes_sent;
      jitter = 1;
      while (bytes_sent - start < 830) begin
         if (bytes_sent - start > 680) jitter = 0;
         if ($urandom_range(0, 11) == 0) begin
            pick = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
               0: val = 64'd0;
               1: val = '1;
               2: val = {56'd0, 8'($urandom_range(1, 4))};
               default: val = {32'($urandom), 32'($urandom)};
            endcase
            write_csr(2'(pick), val);
         end
         pick = $urandom_range(0, 9);
         if (pick < 4) rtype = put_cd;
         else if (pick < 7) rtype = del_cd;
         else rtype = 8'($urandom);
         klen = ($urandom_range(0, 40) == 0) ? 16'($urandom_range(256, 300))
                                             : 16'($urandom_range(0, 6));
         vlen = ($urandom_range(0, 40) == 0) ? 16'($urandom_range(256, 300))
                                             : 16'($urandom_range(0, 10));
         send_record(pick_seq(), $urandom, rtype, klen, vlen,
                     $urandom_range(0, 7) == 0, 1'b0);
      end
      wait_idle();
   endtask

   // ends the run in the halted state: either a CRC mismatch or a cut-off record
   task automatic test_halt_on_error();
      jitter = 0;
      send_record(pick_seq(), $urandom, put_cd, 16'd2, 16'd2, 1'b0, 1'b0);
      if ($urandom_range(0, 1) == 0) begin
         send_record(pick_seq(), $urandom, put_cd, 16'd2, 16'd3, 1'b0, 1'b1);
      end else begin
         build_record(pick_seq(), $urandom, put_cd, 16'd3, 16'd3, 1'b0);
         send_span(0, $urandom_range(1, rec_bytes.size() - 1), 1'b1);
      end
      for (int i = 0; i < 20; i++) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = lrd_pkg::CSR_CHECKPOINT;
      csr_data = '0;
      cp_lsn = '0;
      put_cd = 8'd1;
      del_cd = 8'd2;
      is_halted = 1'b0;
      clear_record();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_layouts();
      test_register_settings();
      test_code_change_mid_record();
      test_output_backpressure();
      test_random_stream();
      test_halt_on_error();
      repeat (10) @(posedge clock);
      if (n_err == 0 && pending_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
